>>> hw/rtl/cped_pkg.sv
// shared constants, types and arithmetic helpers of the carrier phase error detector
`timescale 1ns / 1ps
package cped_pkg;

  localparam int SampleBits   = 16;
  localparam int FractionBits = 8;
  localparam int OutBits      = SampleBits + 1 + FractionBits;
  localparam int IndexBits    = 2;
  localparam int CfgBits      = 16;
  localparam int ProdBits     = 2 * SampleBits + 18;

  // signed q1.31 constants
  localparam logic signed [31:0] InvSqrt2 = 32'sd1518500250;
  localparam logic signed [31:0] CosPi8   = 32'sd1984016189;
  localparam logic signed [31:0] SinPi8   = 32'sd821806413;

  typedef enum logic [2:0] {
    MODE_BPSK  = 3'd0,
    MODE_QPSK  = 3'd1,
    MODE_QAM4  = 3'd2,
    MODE_PSK8  = 3'd3,
    MODE_QAM16 = 3'd4
  } mode_e;

  typedef enum logic [IndexBits-1:0] {
    REG_MODE     = 2'd0,
    REG_MAG_LOW  = 2'd1,
    REG_MAG_HIGH = 2'd2
  } reg_index_e;

  typedef logic signed [SampleBits-1:0] sample_t;

  localparam logic [CfgBits-1:0] MagHighReset = 16'd46341;

  // q1.31 product to integer: truncate toward zero, saturate to a sample
  function automatic sample_t trunc_sat(input logic signed [ProdBits-1:0] p);
    logic signed [ProdBits-1:0] t;
    t = p + (p[ProdBits-1] ? ProdBits'(64'sd2147483647) : ProdBits'(0));
    t = t >>> 31;
    if (t > ProdBits'(64'sd32767)) begin
      return sample_t'(16'sh7fff);
    end else if (t < -ProdBits'(64'sd32768)) begin
      return sample_t'(16'sh8000);
    end
    return sample_t'(t);
  endfunction

  // quadrant rule, integer error before scaling
  function automatic logic signed [SampleBits:0] qam4_err(input sample_t x, input sample_t y);
    logic signed [SampleBits:0] xe;
    logic signed [SampleBits:0] ye;
    xe = (SampleBits+1)'(x);
    ye = (SampleBits+1)'(y);
    if (!x[SampleBits-1] && !y[SampleBits-1]) begin
      return ye - xe;
    end else if (!x[SampleBits-1]) begin
      return xe + ye;
    end else if (y[SampleBits-1] || y == '0) begin
      return xe - ye;
    end
    return xe + ye;
  endfunction

  function automatic logic [SampleBits-1:0] abs_s(input sample_t x);
    return x[SampleBits-1] ? SampleBits'(-x) : SampleBits'(x);
  endfunction

endpackage

>>> hw/rtl/carrier_phase_error_detector.sv
// decision directed carrier phase error detector, six register stages
// an accepted input transaction moves through stages 1 to 6 in order to out_valid_o
// throughput: one transaction per cycle unless stalled; each stage holds one item and
// moves when the stage after it is empty or moving, so a stall drops nothing
// reset: all stage valid bits clear; mode resets to bpsk, magnitude_low to 0,
// magnitude_high to 46341
`timescale 1ns / 1ps
module carrier_phase_error_detector (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cped_pkg::IndexBits-1:0]      cfg_index_i,
  input  logic [cped_pkg::CfgBits-1:0]        cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [cped_pkg::SampleBits-1:0] in_phase_i,
  input  logic signed [cped_pkg::SampleBits-1:0] quadrature_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [cped_pkg::OutBits-1:0] phase_error_o
);
  import cped_pkg::*;

  localparam int NumStages = 6;

  // configuration registers
  logic [2:0]         mode_q;
  logic [CfgBits-1:0] mag_low_q;
  logic [CfgBits-1:0] mag_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_BPSK;
      mag_low_q  <= '0;
      mag_high_q <= MagHighReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MODE:     mode_q     <= cfg_data_i[2:0];
        REG_MAG_LOW:  mag_low_q  <= cfg_data_i;
        REG_MAG_HIGH: mag_high_q <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // stage valid bits and per-stage advance
  logic [NumStages:1]   vld_q;
  logic [NumStages+1:1] adv;

  always_comb begin
    adv[NumStages+1] = !out_stall_i;
    for (int k = NumStages; k >= 1; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[1]) vld_q[1] <= in_valid_i;
      for (int k = 2; k <= NumStages; k++) begin
        if (adv[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign in_stall_o  = !adv[1];
  assign out_valid_o = vld_q[NumStages];

  // stage 1: all products (rotations, squared magnitude, squared thresholds)
  sample_t                       s1_i_q, s1_q_q;
  logic signed [ProdBits-1:0]    s1_pdi_q, s1_psi_q;
  logic signed [ProdBits-1:0]    s1_pic_q, s1_pqs_q, s1_pis_q, s1_pqc_q;
  logic [32:0]                   s1_sqi_q, s1_sqq_q, s1_lo2_q;
  logic [33:0]                   s1_hi2_q;
  logic signed [SampleBits:0]    dif, sum;
  logic [SampleBits:0]           hi_p1;

  always_comb begin
    dif   = (SampleBits+1)'(in_phase_i) - (SampleBits+1)'(quadrature_i);
    sum   = (SampleBits+1)'(in_phase_i) + (SampleBits+1)'(quadrature_i);
    hi_p1 = (SampleBits+1)'(mag_high_q) + (SampleBits+1)'(1);
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s1_i_q   <= in_phase_i;
      s1_q_q   <= quadrature_i;
      s1_pdi_q <= ProdBits'(dif) * ProdBits'(InvSqrt2);
      s1_psi_q <= ProdBits'(sum) * ProdBits'(InvSqrt2);
      s1_pic_q <= ProdBits'(in_phase_i) * ProdBits'(CosPi8);
      s1_pqs_q <= ProdBits'(quadrature_i) * ProdBits'(SinPi8);
      s1_pis_q <= ProdBits'(in_phase_i) * ProdBits'(SinPi8);
      s1_pqc_q <= ProdBits'(quadrature_i) * ProdBits'(CosPi8);
      s1_sqi_q <= 33'($unsigned(33'(in_phase_i) * 33'(in_phase_i)));
      s1_sqq_q <= 33'($unsigned(33'(quadrature_i) * 33'(quadrature_i)));
      s1_lo2_q <= 33'(mag_low_q) * 33'(mag_low_q);
      s1_hi2_q <= 34'(hi_p1) * 34'(hi_p1);
    end
  end

  // stage 2: truncate and saturate rotations, magnitude window test
  // floor(sqrt(m2)) > high iff m2 >= (high+1)^2, and < low iff m2 < low^2
  sample_t     s2_i_q, s2_q_q, s2_qpi_q, s2_qpq_q, s2_rri_q, s2_rrq_q;
  logic        s2_outer_q;
  logic [33:0] mag2;

  assign mag2 = 34'(s1_sqi_q) + 34'(s1_sqq_q);

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      s2_i_q     <= s1_i_q;
      s2_q_q     <= s1_q_q;
      s2_qpi_q   <= trunc_sat(s1_pdi_q);
      s2_qpq_q   <= trunc_sat(s1_psi_q);
      s2_rri_q   <= trunc_sat(s1_pic_q - s1_pqs_q);
      s2_rrq_q   <= trunc_sat(s1_pis_q + s1_pqc_q);
      s2_outer_q <= (mag2 >= s1_hi2_q) || (mag2 < 34'(s1_lo2_q));
    end
  end

  // stage 3: pick the operands per mode, simple rules, 8psk sector squares
  logic signed [SampleBits:0] s3_simple_q;
  logic                       s3_use_simple_q;
  sample_t                    s3_x_q, s3_y_q;
  logic [33:0]                s3_sum2_q, s3_a2x2_q, s3_b2x2_q;
  logic signed [SampleBits:0] simple_d;
  logic                       use_simple_d;
  sample_t                    px, py;
  logic [SampleBits-1:0]      pa, pb;
  logic [SampleBits:0]        pab;

  always_comb begin
    px = s2_rri_q;
    py = s2_rrq_q;
    if (mode_q == MODE_PSK8) begin
      px = s2_i_q;
      py = s2_q_q;
    end
    pa  = abs_s(px);
    pb  = abs_s(py);
    pab = (SampleBits+1)'(pa) + (SampleBits+1)'(pb);
    use_simple_d = 1'b1;
    case (mode_q)
      MODE_QPSK:  simple_d = qam4_err(s2_qpi_q, s2_qpq_q);
      MODE_QAM4:  simple_d = qam4_err(s2_i_q, s2_q_q);
      MODE_PSK8: begin
        simple_d     = qam4_err(s2_i_q, s2_q_q);
        use_simple_d = 1'b0;
      end
      MODE_QAM16: begin
        simple_d     = qam4_err(s2_i_q, s2_q_q);
        use_simple_d = s2_outer_q;
      end
      // bpsk and unused codes
      default: begin
        if (!s2_i_q[SampleBits-1] && s2_i_q != '0) begin
          simple_d = (SampleBits+1)'(s2_q_q);
        end else begin
          simple_d = -(SampleBits+1)'(s2_q_q);
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      s3_simple_q     <= simple_d;
      s3_use_simple_q <= use_simple_d;
      s3_x_q          <= px;
      s3_y_q          <= py;
      s3_sum2_q       <= 34'(pab) * 34'(pab);
      s3_a2x2_q       <= (34'(pa) * 34'(pa)) << 1;
      s3_b2x2_q       <= (34'(pb) * 34'(pb)) << 1;
    end
  end

  // stage 4: 8psk sector decision, integer error or diagonal operand
  logic signed [SampleBits:0] s4_int_q;
  logic                       s4_diag_q, s4_neg_q;
  logic [SampleBits-1:0]      s4_dmag_q;
  logic signed [SampleBits:0] int_d, darg, xe, ye;
  logic                       diag_d;

  always_comb begin
    xe     = (SampleBits+1)'(s3_x_q);
    ye     = (SampleBits+1)'(s3_y_q);
    int_d  = s3_simple_q;
    diag_d = 1'b0;
    darg   = xe + ye;
    if (!s3_use_simple_q) begin
      if (s3_sum2_q < s3_a2x2_q) begin
        int_d = s3_x_q[SampleBits-1] ? -ye : ye;
      end else if (s3_sum2_q < s3_b2x2_q) begin
        int_d = (!s3_y_q[SampleBits-1] && s3_y_q != '0) ? -xe : xe;
      end else begin
        diag_d = 1'b1;
        if (xe > 0 && ye > 0) begin
          darg = ye - xe;
        end else if (xe < 0 && ye > 0) begin
          darg = -(xe + ye);
        end else if (xe < 0 && ye < 0) begin
          darg = xe - ye;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      s4_int_q  <= int_d;
      s4_diag_q <= diag_d;
      s4_neg_q  <= darg[SampleBits];
      s4_dmag_q <= darg[SampleBits] ? SampleBits'(-darg) : SampleBits'(darg);
    end
  end

  // stage 5: diagonal magnitude times 1/sqrt(2)
  localparam int DiagBits = SampleBits + 31;
  logic signed [SampleBits:0] s5_int_q;
  logic                       s5_diag_q, s5_neg_q;
  logic [DiagBits-1:0]        s5_prod_q;

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      s5_int_q  <= s4_int_q;
      s5_diag_q <= s4_diag_q;
      s5_neg_q  <= s4_neg_q;
      s5_prod_q <= DiagBits'(s4_dmag_q) * DiagBits'(InvSqrt2);
    end
  end

  // stage 6: round to nearest, apply sign, output register
  localparam int Shift = 31 - FractionBits;
  logic [DiagBits-1:0] rnd;
  logic [OutBits-1:0]  rmag;
  logic signed [OutBits-1:0] err_d;

  always_comb begin
    rnd  = s5_prod_q + (DiagBits'(1) << (Shift - 1));
    rmag = OutBits'(rnd >> Shift);
    if (s5_diag_q) begin
      err_d = s5_neg_q ? -$signed(rmag) : $signed(rmag);
    end else begin
      err_d = OutBits'(s5_int_q) <<< FractionBits;
    end
  end

  logic signed [OutBits-1:0] err_q;

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      err_q <= err_d;
    end
  end

  assign phase_error_o = err_q;

endmodule

>>> hw/rtl/cped_checker.sv
// port-level checks of the carrier phase error detector, bound to the top level
`timescale 1ns / 1ps
module cped_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_stall_o,
  input logic                                   out_valid_o,
  input logic                                   out_stall_i,
  input logic signed [cped_pkg::OutBits-1:0]    phase_error_o
);
  import cped_pkg::*;

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped under stall");

  // a stalled result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(phase_error_o))
    else $error("result changed under stall");

  // with the output side free the pipeline always takes input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output free");

  // an empty output stage never holds back input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

endmodule

bind carrier_phase_error_detector cped_checker u_cped_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .phase_error_o (phase_error_o)
);
